### rtl/dhd_pkg.sv
// ----------------------------------------------------------------------------
// dhd_pkg
// shared types, register map and default constants of the detection decoder
// ----------------------------------------------------------------------------
package dhd_pkg;

    // default geometry and class limit
    localparam int MAX_CLASSES_DEF  = 100;
    localparam int MODEL_WIDTH_DEF  = 640;
    localparam int MODEL_HEIGHT_DEF = 640;

    // queue depths
    localparam int CAND_DEPTH = 4;
    localparam int OUT_DEPTH  = 8;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_CLASS_COUNT     = 3'd0;
    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_PAD_LEFT        = 3'd2;
    localparam logic [2:0] REG_PAD_TOP         = 3'd3;
    localparam logic [2:0] REG_INVERSE_SCALE   = 3'd4;
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd5;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd6;

    // register reset values
    localparam logic [6:0]  RST_CLASS_COUNT     = 7'd8;
    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd19661;
    localparam logic [10:0] RST_PAD             = 11'd0;
    localparam logic [15:0] RST_INVERSE_SCALE   = 16'd4096;
    localparam logic [11:0] RST_FRAME_SIZE      = 12'd640;

    typedef struct packed {
        logic [6:0]  class_count;
        logic [15:0] score_threshold;
        logic [10:0] pad_left_px;
        logic [10:0] pad_top_px;
        logic [15:0] inverse_scale;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } t_cfg;

    // candidate that passed the score test, front to back
    typedef struct packed {
        logic [6:0]         class_idx;
        logic [15:0]        confidence;
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
    } t_cand;

    // decoded result beat
    typedef struct packed {
        logic [6:0]         class_idx;
        logic [15:0]        confidence;
        logic [11:0]        left_px;
        logic [11:0]        top_px;
        logic [11:0]        width_px;
        logic [11:0]        height_px;
        logic signed [15:0] frame_centre_x;
        logic signed [15:0] frame_centre_y;
    } t_result;

    // back-end status toward the top level
    typedef struct packed {
        logic cand_pop;
        logic s1_valid;
        logic out_push;
    } t_back_stat;

endpackage

### rtl/dhd_fifo.sv
// ----------------------------------------------------------------------------
// dhd_fifo
// small register queue with show-ahead head and occupancy count
// ----------------------------------------------------------------------------
module dhd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/dhd_front.sv
// ----------------------------------------------------------------------------
// dhd_front
// running arg-max over class scores, emits candidates that pass threshold
// ----------------------------------------------------------------------------
module dhd_front #(
    parameter int MAX_CLASSES = dhd_pkg::MAX_CLASSES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dhd_pkg::t_cfg       i_cfg,
    input  logic                i_accept,
    input  logic [15:0]         i_class_score,
    input  logic                i_last_class,
    input  logic signed [15:0]  i_centre_x,
    input  logic signed [15:0]  i_centre_y,
    input  logic [14:0]         i_box_width,
    input  logic [14:0]         i_box_height,
    output logic                o_cand_push,
    output dhd_pkg::t_cand      o_cand
);

    localparam logic [7:0] MaxCls = 8'(MAX_CLASSES);

    logic [15:0] r_best_score, n_best_score;
    logic [6:0]  r_best_index, n_best_index;
    logic        r_have_winner, n_have_winner;
    logic [6:0]  r_class_counter;
    logic        w_compete;

    // a score competes only inside both class limits, strict compare keeps ties
    assign w_compete = (r_class_counter < i_cfg.class_count) &&
                       ({1'b0, r_class_counter} < MaxCls) &&
                       (i_class_score > r_best_score);

    assign n_best_score  = w_compete ? i_class_score : r_best_score;
    assign n_best_index  = w_compete ? r_class_counter : r_best_index;
    assign n_have_winner = r_have_winner || w_compete;

    assign o_cand_push = i_accept && i_last_class && n_have_winner &&
                         (n_best_score >= i_cfg.score_threshold);

    always_comb begin
        o_cand.class_idx  = n_best_index;
        o_cand.confidence = n_best_score;
        o_cand.centre_x   = i_centre_x;
        o_cand.centre_y   = i_centre_y;
        o_cand.box_width  = i_box_width;
        o_cand.box_height = i_box_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score    <= '0;
            r_best_index    <= '0;
            r_have_winner   <= 1'b0;
            r_class_counter <= '0;
        end else if (i_accept) begin
            if (i_last_class) begin
                r_best_score    <= '0;
                r_best_index    <= '0;
                r_have_winner   <= 1'b0;
                r_class_counter <= '0;
            end else begin
                r_best_score  <= n_best_score;
                r_best_index  <= n_best_index;
                r_have_winner <= n_have_winner;
                if (r_class_counter != 7'h7F) begin
                    r_class_counter <= r_class_counter + 1'b1;
                end
            end
        end
    end

endmodule

### rtl/dhd_back.sv
// ----------------------------------------------------------------------------
// dhd_back
// three-stage box decode: model clip, letterbox multiply, frame clip
// ----------------------------------------------------------------------------
module dhd_back #(
    parameter int MODEL_WIDTH  = dhd_pkg::MODEL_WIDTH_DEF,
    parameter int MODEL_HEIGHT = dhd_pkg::MODEL_HEIGHT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dhd_pkg::t_cfg          i_cfg,
    input  logic                   i_cand_empty,
    input  dhd_pkg::t_cand         i_cand,
    output logic                   o_cand_pop,
    input  logic [$clog2(dhd_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                   o_out_push,
    output dhd_pkg::t_result       o_result,
    output dhd_pkg::t_back_stat    o_stat
);

    localparam int OcW = $clog2(dhd_pkg::OUT_DEPTH+1);
    localparam logic signed [17:0] LimX = 18'(MODEL_WIDTH * 32);
    localparam logic signed [17:0] LimY = 18'(MODEL_HEIGHT * 32);

    // stage 1: corners, model clip, pad removal
    logic signed [17:0] w_two_c [2];
    logic signed [17:0] w_size  [2];
    logic signed [17:0] w_a     [2];
    logic signed [17:0] w_b     [2];
    logic signed [17:0] w_a_c   [2];
    logic signed [17:0] w_b_c   [2];
    logic signed [17:0] w_lim   [2];
    logic [15:0]        w_pad   [2];
    logic               r_s1_valid;
    logic [6:0]         r_s1_class;
    logic [15:0]        r_s1_conf;
    logic signed [18:0] r_s1_ap [2];
    logic signed [18:0] r_s1_bp [2];
    logic signed [18:0] r_s1_cp [2];
    logic               r_s1_ok [2];

    // stage 2: products
    logic               r_s2_valid;
    logic [6:0]         r_s2_class;
    logic [15:0]        r_s2_conf;
    logic signed [35:0] r_s2_fa [2];
    logic signed [35:0] r_s2_fb [2];
    logic signed [35:0] r_s2_fc [2];
    logic               r_s2_ok [2];
    logic signed [16:0] w_scale;

    // stage 3: frame clip, truncate, saturate
    logic signed [35:0] w_fl    [2];
    logic signed [35:0] w_fa_c  [2];
    logic signed [35:0] w_fb_c  [2];
    logic signed [35:0] w_diff  [2];
    logic signed [22:0] w_fc_sh [2];
    logic [15:0]        w_cen   [2];
    logic               w_ok    [2];
    logic               r_s3_valid;

    logic [OcW:0]       w_used;

    // keep room in the output queue for every beat in flight
    assign w_used     = {1'b0, i_out_count} + (OcW+1)'(r_s1_valid) +
                        (OcW+1)'(r_s2_valid) + (OcW+1)'(r_s3_valid);
    assign o_cand_pop = !i_cand_empty && (w_used < (OcW+1)'(dhd_pkg::OUT_DEPTH));
    assign w_scale    = $signed({1'b0, i_cfg.inverse_scale});

    always_comb begin
        w_two_c[0] = $signed({i_cand.centre_x[15], i_cand.centre_x, 1'b0});
        w_two_c[1] = $signed({i_cand.centre_y[15], i_cand.centre_y, 1'b0});
        w_size[0]  = $signed({3'b000, i_cand.box_width});
        w_size[1]  = $signed({3'b000, i_cand.box_height});
        w_lim[0]   = LimX;
        w_lim[1]   = LimY;
        w_pad[0]   = {i_cfg.pad_left_px, 5'b00000};
        w_pad[1]   = {i_cfg.pad_top_px, 5'b00000};
        w_fl[0]    = $signed({7'b0, i_cfg.frame_width, 17'b0});
        w_fl[1]    = $signed({7'b0, i_cfg.frame_height, 17'b0});
        for (int k = 0; k < 2; k++) begin
            w_a[k]   = w_two_c[k] - w_size[k];
            w_b[k]   = w_two_c[k] + w_size[k];
            w_a_c[k] = w_a[k][17] ? '0 : w_a[k];
            w_b_c[k] = (w_b[k] > w_lim[k]) ? w_lim[k] : w_b[k];

            w_fa_c[k]  = r_s2_fa[k][35] ? '0 : r_s2_fa[k];
            w_fb_c[k]  = (r_s2_fb[k] > w_fl[k]) ? w_fl[k] : r_s2_fb[k];
            w_diff[k]  = w_fb_c[k] - w_fa_c[k];
            w_ok[k]    = r_s2_ok[k] && (w_fb_c[k] > w_fa_c[k]);
            // floor toward minus infinity to Q12.4, then saturate
            w_fc_sh[k] = r_s2_fc[k][35:13];
            if (w_fc_sh[k] > 23'sd32767) begin
                w_cen[k] = 16'h7FFF;
            end else if (w_fc_sh[k] < -23'sd32768) begin
                w_cen[k] = 16'h8000;
            end else begin
                w_cen[k] = w_fc_sh[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_cand_pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && w_ok[0] && w_ok[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_class <= i_cand.class_idx;
        r_s1_conf  <= i_cand.confidence;
        r_s2_class <= r_s1_class;
        r_s2_conf  <= r_s1_conf;
        for (int k = 0; k < 2; k++) begin
            r_s1_ap[k] <= {w_a_c[k][17], w_a_c[k]} - $signed({3'b000, w_pad[k]});
            r_s1_bp[k] <= {w_b_c[k][17], w_b_c[k]} - $signed({3'b000, w_pad[k]});
            r_s1_cp[k] <= {w_two_c[k][17], w_two_c[k]} - $signed({3'b000, w_pad[k]});
            r_s1_ok[k] <= w_b_c[k] > w_a_c[k];
            r_s2_fa[k] <= r_s1_ap[k] * w_scale;
            r_s2_fb[k] <= r_s1_bp[k] * w_scale;
            r_s2_fc[k] <= r_s1_cp[k] * w_scale;
            r_s2_ok[k] <= r_s1_ok[k];
        end
        o_result.class_idx      <= r_s2_class;
        o_result.confidence     <= r_s2_conf;
        o_result.left_px        <= w_fa_c[0][28:17];
        o_result.top_px         <= w_fa_c[1][28:17];
        o_result.width_px       <= w_diff[0][28:17];
        o_result.height_px      <= w_diff[1][28:17];
        o_result.frame_centre_x <= w_cen[0];
        o_result.frame_centre_y <= w_cen[1];
    end

    assign o_out_push      = r_s3_valid;
    assign o_stat.cand_pop = o_cand_pop;
    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.out_push = r_s3_valid;

endmodule

### rtl/detection_head_decoder.sv
// ----------------------------------------------------------------------------
// detection_head_decoder
// class arg-max, threshold and letterbox undo for one-stage detector output
// ----------------------------------------------------------------------------
// throughput: one score beat per cycle while the candidate queue is not full, also across candidates
// path from the accepted last beat to its result on the output:
//   (candidate queue, three decode stages, output queue)
// the front stalls only when the candidate queue is full; the back issues while
//   the output queue has room for everything in its three stages
// reset: synchronous active low; clears queues, pipeline and arg-max state and
//   loads the documented register defaults
module detection_head_decoder #(
    parameter int MAX_CLASSES  = dhd_pkg::MAX_CLASSES_DEF,
    parameter int MODEL_WIDTH  = dhd_pkg::MODEL_WIDTH_DEF,
    parameter int MODEL_HEIGHT = dhd_pkg::MODEL_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // score beats
    input  logic               push,
    output logic               full,
    input  logic [15:0]        i_class_score,
    input  logic               i_last_class,
    input  logic signed [15:0] i_centre_x,
    input  logic signed [15:0] i_centre_y,
    input  logic [14:0]        i_box_width,
    input  logic [14:0]        i_box_height,
    // result beats
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         o_class_idx,
    output logic [15:0]        o_confidence,
    output logic [11:0]        o_left_px,
    output logic [11:0]        o_top_px,
    output logic [11:0]        o_width_px,
    output logic [11:0]        o_height_px,
    output logic signed [15:0] o_frame_centre_x,
    output logic signed [15:0] o_frame_centre_y
);

    localparam int CandW = $bits(dhd_pkg::t_cand);
    localparam int ResW  = $bits(dhd_pkg::t_result);
    localparam int CcW   = $clog2(dhd_pkg::CAND_DEPTH+1);
    localparam int OcW   = $clog2(dhd_pkg::OUT_DEPTH+1);

    dhd_pkg::t_cfg       r_cfg;
    logic                w_cfg_wr;
    logic [2:0]          w_reg_idx;

    logic                w_in_accept;
    logic                w_cand_push;
    dhd_pkg::t_cand      w_cand_in;
    dhd_pkg::t_cand      w_cand_head;
    logic                w_cand_full;
    logic                w_cand_empty;
    logic [CcW-1:0]      w_cand_count;
    logic                w_cand_pop;

    logic                w_out_push;
    logic                w_out_full;
    logic [OcW-1:0]      w_out_count;
    dhd_pkg::t_result    w_res_in;
    dhd_pkg::t_result    w_res_head;
    dhd_pkg::t_back_stat w_stat;

    // ------------------------------------------------------------------
    // register file: writes land on the access phase, reads are plain muxes
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count     <= dhd_pkg::RST_CLASS_COUNT;
            r_cfg.score_threshold <= dhd_pkg::RST_SCORE_THRESHOLD;
            r_cfg.pad_left_px     <= dhd_pkg::RST_PAD;
            r_cfg.pad_top_px      <= dhd_pkg::RST_PAD;
            r_cfg.inverse_scale   <= dhd_pkg::RST_INVERSE_SCALE;
            r_cfg.frame_width     <= dhd_pkg::RST_FRAME_SIZE;
            r_cfg.frame_height    <= dhd_pkg::RST_FRAME_SIZE;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                dhd_pkg::REG_CLASS_COUNT:     r_cfg.class_count     <= pwdata[6:0];
                dhd_pkg::REG_SCORE_THRESHOLD: r_cfg.score_threshold <= pwdata[15:0];
                dhd_pkg::REG_PAD_LEFT:        r_cfg.pad_left_px     <= pwdata[10:0];
                dhd_pkg::REG_PAD_TOP:         r_cfg.pad_top_px      <= pwdata[10:0];
                dhd_pkg::REG_INVERSE_SCALE:   r_cfg.inverse_scale   <= pwdata[15:0];
                dhd_pkg::REG_FRAME_WIDTH:     r_cfg.frame_width     <= pwdata[11:0];
                dhd_pkg::REG_FRAME_HEIGHT:    r_cfg.frame_height    <= pwdata[11:0];
                default: ;  // unmapped address, write ignored
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            dhd_pkg::REG_CLASS_COUNT:     prdata = {25'b0, r_cfg.class_count};
            dhd_pkg::REG_SCORE_THRESHOLD: prdata = {16'b0, r_cfg.score_threshold};
            dhd_pkg::REG_PAD_LEFT:        prdata = {21'b0, r_cfg.pad_left_px};
            dhd_pkg::REG_PAD_TOP:         prdata = {21'b0, r_cfg.pad_top_px};
            dhd_pkg::REG_INVERSE_SCALE:   prdata = {16'b0, r_cfg.inverse_scale};
            dhd_pkg::REG_FRAME_WIDTH:     prdata = {20'b0, r_cfg.frame_width};
            dhd_pkg::REG_FRAME_HEIGHT:    prdata = {20'b0, r_cfg.frame_height};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front: arg-max on every score beat, candidates go to a short queue
    // ------------------------------------------------------------------
    assign full        = w_cand_full;
    assign w_in_accept = push && !full;

    dhd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (w_in_accept),
        .i_class_score (i_class_score),
        .i_last_class  (i_last_class),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .o_cand_push   (w_cand_push),
        .o_cand        (w_cand_in)
    );

    dhd_fifo #(
        .WIDTH (CandW),
        .DEPTH (dhd_pkg::CAND_DEPTH)
    ) u_cand_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cand_push),
        .i_data  (w_cand_in),
        .o_full  (w_cand_full),
        .i_pop   (w_cand_pop),
        .o_data  (w_cand_head),
        .o_empty (w_cand_empty),
        .o_count (w_cand_count)
    );

    // ------------------------------------------------------------------
    // back: box decode pipeline, results parked in the output queue
    // ------------------------------------------------------------------
    dhd_back #(
        .MODEL_WIDTH  (MODEL_WIDTH),
        .MODEL_HEIGHT (MODEL_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cand_empty (w_cand_empty),
        .i_cand       (w_cand_head),
        .o_cand_pop   (w_cand_pop),
        .i_out_count  (w_out_count),
        .o_out_push   (w_out_push),
        .o_result     (w_res_in),
        .o_stat       (w_stat)
    );

    dhd_fifo #(
        .WIDTH (ResW),
        .DEPTH (dhd_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_res_in),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    // result beat fields straight off the queue head
    assign o_class_idx      = w_res_head.class_idx;
    assign o_confidence     = w_res_head.confidence;
    assign o_left_px        = w_res_head.left_px;
    assign o_top_px         = w_res_head.top_px;
    assign o_width_px       = w_res_head.width_px;
    assign o_height_px      = w_res_head.height_px;
    assign o_frame_centre_x = w_res_head.frame_centre_x;
    assign o_frame_centre_y = w_res_head.frame_centre_y;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the credit scheme must never let a decoded beat hit a full queue
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.out_push |-> !w_out_full)
        else $error("result pushed into full output queue");

    // a popped candidate enters the first decode stage in the next cycle
    a_issue_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.cand_pop |=> w_stat.s1_valid)
        else $error("issued candidate missing from decode stage");

    // candidate queue occupancy stays within its depth
    a_cand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand_count <= CcW'(dhd_pkg::CAND_DEPTH))
        else $error("candidate queue count out of range");

    // a candidate is only queued on an accepted last score beat
    a_cand_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand_push |-> (w_in_accept && i_last_class))
        else $error("candidate queued without last beat");

endmodule
